### rtl/core/fepd_pkg.sv
// ----------------------------------------------------------------------------
// fepd_pkg
// Shared constants and types of the flat-Earth polar distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fepd_pkg;

	typedef logic [31:0]        x2_t;
	typedef logic signed [32:0] acc_t;

	localparam logic [26:0] DEG_TO_RAD = 27'd74961321;
	localparam logic [28:0] EARTH_R    = 29'd417530446;
	localparam acc_t        ONE_Q30    = 33'sd1073741824;
	localparam logic [31:0] DIST_MAX   = 32'd2700000000;
	localparam int          COS_TERMS  = 9;
	localparam int          SQRT_STEPS = 32;
	localparam int          COS_STAGES = 3;
	localparam int          LATENCY    = 9 + COS_TERMS * COS_STAGES + 4 + SQRT_STEPS + 2;

	function automatic int cos_den(int k);
		return (2 * k - 1) * (2 * k);
	endfunction

endpackage

`default_nettype wire

### rtl/core/fepd_cos_term.sv
// ----------------------------------------------------------------------------
// fepd_cos_term
// One Horner step of the cosine series: acc = 1 - x2 * acc / DEN, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fepd_cos_term #(
	parameter int DEN = 2
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  fepd_pkg::x2_t     in_x2,
	input  fepd_pkg::acc_t    in_acc,
	output logic              out_valid,
	output fepd_pkg::x2_t     out_x2,
	output fepd_pkg::acc_t    out_acc
);

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DEN);
	localparam logic [31:0] DEN_W = 32'(DEN);

	logic          v_s1, v_s2;
	logic [61:0]   prod_s1;
	fepd_pkg::x2_t x2_s1, x2_s2;
	logic [31:0]   quo_s2;
	logic [63:0]   m_s2;
	logic [31:0]   qe_c, rem_c, q_c;

	always_comb begin
		qe_c  = m_s2[63:32];
		rem_c = quo_s2 - 32'(64'(qe_c) * 64'(DEN_W));
		q_c   = (rem_c >= DEN_W) ? qe_c + 32'd1 : qe_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 62'(in_x2) * 62'(in_acc[30:0]);
		x2_s1   <= in_x2;
		quo_s2  <= prod_s1[61:30];
		m_s2    <= 64'(prod_s1[61:30]) * 64'(RECIP);
		x2_s2   <= x2_s1;
		out_x2  <= x2_s2;
		out_acc <= fepd_pkg::ONE_Q30 - fepd_pkg::acc_t'({1'b0, q_c});
	end

endmodule

`default_nettype wire

### rtl/core/flat_earth_polar_distance.sv
// ----------------------------------------------------------------------------
// flat_earth_polar_distance
// Flat-Earth polar-coordinate distance between two latitude/longitude points.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with lat_a, lon_a, lat_b, lon_b valid; a transaction is taken
//   at every rising edge with start high and busy low. busy stays low, so one
//   transaction may enter on every cycle.
//   Each result appears on distance_km with done high for exactly one cycle,
//   in order of entry. Throughput is one transaction per cycle; the pipeline
//   includes the 27-stage cosine series (nine shared-form Horner steps of
//   three stages) and the 32-stage bit-serial square root.
//   Reset clears all valid bits; nothing is in flight afterwards.
//   The receiver cannot stall: results are presented once and not held.
//   Angles are degrees times 2^FRAC_BITS, the distance is km times
//   2^FRAC_BITS, saturated at 2700000000.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_earth_polar_distance #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed [23:0]  lat_a,
	input  wire signed [24:0]  lon_a,
	input  wire signed [23:0]  lat_b,
	input  wire signed [24:0]  lon_b,
	output logic               done,
	output logic [31:0]        distance_km
);

	localparam logic [63:0] QUARTER = 64'd90 << FRAC_BITS;
	localparam logic [63:0] HALF    = 64'd180 << FRAC_BITS;
	localparam logic [63:0] FULL    = 64'd360 << FRAC_BITS;
	localparam logic [25:0] RECIP   = 26'((64'd1 << 26) / FULL);
	localparam int RAD_SH = FRAC_BITS + 4;
	localparam int CW     = (FRAC_BITS + 9 > 26) ? FRAC_BITS + 9 : 26;
	localparam int PW     = CW + 28;
	localparam int TW     = PW - RAD_SH;
	localparam int QW     = TW + 4;
	localparam int RW     = 2 * TW + 6;
	localparam int CHAIN  = fepd_pkg::COS_TERMS * fepd_pkg::COS_STAGES;
	localparam int SIDE_N = CHAIN + 5;

	typedef struct packed {
		logic signed [TW-1:0] t1;
		logic signed [TW-1:0] t2;
		logic                 neg;
	} side_t;

	function automatic logic [127:0] rnd_s(logic [127:0] v, int s);
		logic [127:0] mag;
		logic [127:0] m;
		mag = v[127] ? -v : v;
		m   = (mag + (128'd1 << (s - 1))) >> s;
		return v[127] ? -m : m;
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [CW-1:0] ca_s1, cb_s1;
	logic signed [25:0]   dl_s1;
	logic signed [PW-1:0] pa_s2, pb_s2;
	logic [25:0]          a_s2, a_s3;
	logic [51:0]          aq_s2;
	logic signed [TW-1:0] t1_s3, t2_s3, t1_s4, t2_s4;
	logic [26:0]          pq_s3;
	logic [25:0]          rm_s4, d_s5;
	logic [52:0]          dp_s6;
	logic [28:0]          x_s7;
	logic [57:0]          xx_s8;
	fepd_pkg::x2_t        x2_s9;

	logic [26:0] rr_c;
	logic [25:0] rm_c, f1_c, d_c;
	logic        neg_c;

	always_comb begin
		rr_c  = 27'(a_s3) - pq_s3;
		rm_c  = (64'(rr_c) >= FULL) ? 26'(64'(rr_c) - FULL) : 26'(rr_c);
		f1_c  = (64'(rm_s4) > HALF) ? 26'(FULL - 64'(rm_s4)) : rm_s4;
		neg_c = 64'(f1_c) > QUARTER;
		d_c   = neg_c ? 26'(HALF - 64'(f1_c)) : f1_c;
	end

	side_t side_s [SIDE_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		ca_s1 <= $signed(QUARTER[CW-1:0]) - CW'(lat_a);
		cb_s1 <= $signed(QUARTER[CW-1:0]) - CW'(lat_b);
		dl_s1 <= 26'(lon_a) - 26'(lon_b);
		pa_s2 <= PW'(ca_s1) * PW'($signed({1'b0, fepd_pkg::DEG_TO_RAD}));
		pb_s2 <= PW'(cb_s1) * PW'($signed({1'b0, fepd_pkg::DEG_TO_RAD}));
		a_s2  <= dl_s1[25] ? 26'(-dl_s1) : 26'(dl_s1);
		aq_s2 <= 52'(dl_s1[25] ? 26'(-dl_s1) : 26'(dl_s1)) * 52'(RECIP);
		t1_s3 <= TW'(rnd_s(128'(pa_s2), RAD_SH));
		t2_s3 <= TW'(rnd_s(128'(pb_s2), RAD_SH));
		a_s3  <= a_s2;
		pq_s3 <= 27'(64'(aq_s2[51:26]) * FULL);
		rm_s4 <= rm_c;
		t1_s4 <= t1_s3;
		t2_s4 <= t2_s3;
		d_s5  <= d_c;
		side_s[0] <= '{t1: t1_s4, t2: t2_s4, neg: neg_c};
		dp_s6 <= 53'(d_s5) * 53'(fepd_pkg::DEG_TO_RAD);
		x_s7  <= 29'(rnd_s(128'(dp_s6), RAD_SH));
		xx_s8 <= 58'(x_s7) * 58'(x_s7);
		x2_s9 <= 32'(rnd_s(128'(xx_s8), 26));
	end

	for (genvar k = 1; k < SIDE_N; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k] <= side_s[k-1];
		end
	end

	logic           ch_v   [fepd_pkg::COS_TERMS + 1];
	fepd_pkg::x2_t  ch_x2  [fepd_pkg::COS_TERMS + 1];
	fepd_pkg::acc_t ch_acc [fepd_pkg::COS_TERMS + 1];

	assign ch_v[0]   = v_s9;
	assign ch_x2[0]  = x2_s9;
	assign ch_acc[0] = fepd_pkg::ONE_Q30;

	for (genvar i = 0; i < fepd_pkg::COS_TERMS; i++) begin : g_cos
		fepd_cos_term #(
			.DEN(fepd_pkg::cos_den(fepd_pkg::COS_TERMS - i))
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (ch_v[i]),
			.in_x2    (ch_x2[i]),
			.in_acc   (ch_acc[i]),
			.out_valid(ch_v[i+1]),
			.out_x2   (ch_x2[i+1]),
			.out_acc  (ch_acc[i+1])
		);
	end

	side_t                   sd_c;
	logic signed [33:0]      c_c;
	logic                    v_s37, v_s38, v_s39;
	logic signed [TW+33:0]   qp_s37;
	logic signed [2*TW-1:0]  sq1_s37, sq2_s37;
	logic signed [TW-1:0]    t1_s37, t1_s38;
	logic signed [QW-1:0]    q_s38;
	logic signed [2*TW:0]    ss_s38, ss_s39;
	logic signed [TW+QW-1:0] tq_s39;
	logic signed [RW-1:0]    r_c;

	always_comb begin
		sd_c = side_s[SIDE_N-1];
		c_c  = sd_c.neg ? -34'(ch_acc[fepd_pkg::COS_TERMS])
		                : 34'(ch_acc[fepd_pkg::COS_TERMS]);
		r_c  = RW'(ss_s39) - (RW'(tq_s39) <<< 1);
	end

	logic        vr_s   [fepd_pkg::SQRT_STEPS + 1];
	logic [63:0] rem_s  [fepd_pkg::SQRT_STEPS + 1];
	logic [63:0] root_s [fepd_pkg::SQRT_STEPS + 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s37    <= 1'b0;
			v_s38    <= 1'b0;
			v_s39    <= 1'b0;
			vr_s[0]  <= 1'b0;
		end else begin
			v_s37    <= ch_v[fepd_pkg::COS_TERMS];
			v_s38    <= v_s37;
			v_s39    <= v_s38;
			vr_s[0]  <= v_s39;
		end
	end

	always_ff @(posedge clk) begin
		qp_s37    <= (TW+34)'(sd_c.t2) * (TW+34)'(c_c);
		sq1_s37   <= (2*TW)'(sd_c.t1) * (2*TW)'(sd_c.t1);
		sq2_s37   <= (2*TW)'(sd_c.t2) * (2*TW)'(sd_c.t2);
		t1_s37    <= sd_c.t1;
		q_s38     <= QW'(rnd_s(128'(qp_s37), 30));
		ss_s38    <= (2*TW+1)'(sq1_s37) + (2*TW+1)'(sq2_s37);
		t1_s38    <= t1_s37;
		tq_s39    <= (TW+QW)'(t1_s38) * (TW+QW)'(q_s38);
		ss_s39    <= ss_s38;
		rem_s[0]  <= r_c[RW-1] ? 64'd0 : 64'(r_c);
		root_s[0] <= 64'd0;
	end

	for (genvar k = 1; k <= fepd_pkg::SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (64 - 2 * k);
		logic [63:0] trial_c;
		assign trial_c = root_s[k-1] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vr_s[k] <= 1'b0;
			end else begin
				vr_s[k] <= vr_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[k-1] >= trial_c) begin
				rem_s[k]  <= rem_s[k-1] - trial_c;
				root_s[k] <= (root_s[k-1] >> 1) + BIT;
			end else begin
				rem_s[k]  <= rem_s[k-1];
				root_s[k] <= root_s[k-1] >> 1;
			end
		end
	end

	logic        v_s73;
	logic [60:0] dp_s73;
	logic [63:0] dist_c;

	always_comb begin
		dist_c = 64'(rnd_s(128'(dp_s73), 44 - FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s73 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s73 <= vr_s[fepd_pkg::SQRT_STEPS];
			done  <= v_s73;
		end
	end

	always_ff @(posedge clk) begin
		dp_s73 <= 61'(root_s[fepd_pkg::SQRT_STEPS][31:0]) * 61'(fepd_pkg::EARTH_R);
		distance_km <= (dist_c > 64'(fepd_pkg::DIST_MAX)) ? fepd_pkg::DIST_MAX
		                                                   : dist_c[31:0];
	end

endmodule

`default_nettype wire

### rtl/core/fepd_checker.sv
// ----------------------------------------------------------------------------
// fepd_checker
// Port-level checks of the distance pipeline: timing, range, determinism.
// ----------------------------------------------------------------------------
`default_nettype none

module fepd_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire signed [23:0] lat_a,
	input wire signed [24:0] lon_a,
	input wire signed [23:0] lat_b,
	input wire signed [24:0] lon_b,
	input wire               done,
	input wire [31:0]        distance_km
);

	localparam int LAT = fepd_pkg::LATENCY;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> distance_km <= fepd_pkg::DIST_MAX)
		else $error("distance above saturation bound");

	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done)
		 && $past(lat_a, LAT) == $past(lat_a, LAT + 1)
		 && $past(lon_a, LAT) == $past(lon_a, LAT + 1)
		 && $past(lat_b, LAT) == $past(lat_b, LAT + 1)
		 && $past(lon_b, LAT) == $past(lon_b, LAT + 1))
		|-> $stable(distance_km))
		else $error("equal transactions gave different distances");

endmodule

bind flat_earth_polar_distance fepd_checker u_fepd_checker (.*);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams latitude/longitude pairs into flat_earth_polar_distance and checks
// every distance against a bit-exact integer predictor, in order of entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int FRAC_BITS = 16;
	localparam longint QUARTER = longint'(90) <<< FRAC_BITS;
	localparam longint HALF    = longint'(180) <<< FRAC_BITS;
	localparam longint FULL    = longint'(360) <<< FRAC_BITS;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic signed [23:0] lat_a;
		logic signed [24:0] lon_a;
		logic signed [23:0] lat_b;
		logic signed [24:0] lon_b;
	} point_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [23:0] lat_a = '0;
	logic signed [24:0] lon_a = '0;
	logic signed [23:0] lat_b = '0;
	logic signed [24:0] lon_b = '0;
	wire busy;
	wire done;
	wire [31:0] distance_km;

	point_pair_t pending_pairs[$];
	logic [31:0] expected_dist[$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	logic stim_done = 1'b0;

	flat_earth_polar_distance #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.done(done), .distance_km(distance_km)
	);

	always #5 clk = ~clk;

	function automatic longint round_shift(longint v, int s);
		longint d;
		longint h;
		d = longint'(1) <<< s;
		h = d / 2;
		return (v >= 0) ? (v + h) / d : (v - h) / d;
	endfunction

	function automatic longint deg_to_rad(longint deg);
		return round_shift(deg * longint'(fepd_pkg::DEG_TO_RAD), FRAC_BITS + 4);
	endfunction

	function automatic longint cosine_q30(longint x);
		longint x2;
		longint acc;
		longint den;
		x2 = round_shift(x * x, 26);
		acc = longint'(1) <<< 30;
		for (int k = 9; k >= 1; k--) begin
			den = longint'((2 * k - 1) * (2 * k)) <<< 30;
			acc = (longint'(1) <<< 30) - (x2 * acc) / den;
		end
		return acc;
	endfunction

	function automatic longint floor_root(longint unsigned v);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned bitv;
		rem = v;
		root = 0;
		bitv = longint'(1) <<< 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(root);
	endfunction

	function automatic logic [31:0] polar_distance(point_pair_t p);
		longint t1;
		longint t2;
		longint d;
		longint c;
		longint q;
		longint r;
		longint dist_v;
		logic neg;
		t1 = deg_to_rad(QUARTER - longint'(p.lat_a));
		t2 = deg_to_rad(QUARTER - longint'(p.lat_b));
		d = (longint'(p.lon_a) - longint'(p.lon_b)) % FULL;
		neg = 1'b0;
		if (d < 0) begin
			d = -d;
		end
		if (d > HALF) begin
			d = FULL - d;
		end
		if (d > QUARTER) begin
			d = HALF - d;
			neg = 1'b1;
		end
		c = cosine_q30(deg_to_rad(d));
		if (neg) begin
			c = -c;
		end
		q = round_shift(t2 * c, 30);
		r = t1 * t1 + t2 * t2 - 2 * (t1 * q);
		if (r < 0) begin
			r = 0;
		end
		dist_v = round_shift(floor_root(r) * longint'(fepd_pkg::EARTH_R), 44 - FRAC_BITS);
		if (dist_v > longint'(fepd_pkg::DIST_MAX)) begin
			dist_v = longint'(fepd_pkg::DIST_MAX);
		end
		return dist_v[31:0];
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			p = point_pair_t'(98'({$urandom, $urandom, $urandom, $urandom}));
		end else begin
			p.lat_a = 24'($signed($urandom_range(0, 11796480)) - 32'sd5898240);
			p.lat_b = 24'($signed($urandom_range(0, 11796480)) - 32'sd5898240);
			p.lon_a = 25'($signed($urandom_range(0, 23592960)) - 32'sd11796480);
			p.lon_b = 25'($signed($urandom_range(0, 23592960)) - 32'sd11796480);
			if (mode == 1) begin
				p.lat_b = p.lat_a;
				p.lon_b = p.lon_a + $signed(25'($urandom_range(0, 64))) - 25'sd32;
			end
		end
		return p;
	endfunction

	function automatic point_pair_t make_pair(longint la, longint oa, longint lb, longint ob);
		point_pair_t p;
		p.lat_a = la[23:0];
		p.lon_a = oa[24:0];
		p.lat_b = lb[23:0];
		p.lon_b = ob[24:0];
		return p;
	endfunction

	initial begin
		longint lat_max;
		longint lon_max;
		lat_max = 5898240;
		lon_max = 11796480;
		pending_pairs.push_back(make_pair(0, 0, 0, 0));
		pending_pairs.push_back(make_pair(lat_max, 0, lat_max, 0));
		pending_pairs.push_back(make_pair(-lat_max, 0, -lat_max, 0));
		pending_pairs.push_back(make_pair(lat_max, 0, -lat_max, 0));
		pending_pairs.push_back(make_pair(-lat_max, lon_max, -lat_max, -lon_max));
		pending_pairs.push_back(make_pair(-lat_max, lon_max, -lat_max, 0));
		pending_pairs.push_back(make_pair(-lat_max, -lon_max, -lat_max, lon_max / 2));
		pending_pairs.push_back(make_pair(0, QUARTER, 0, 0));
		pending_pairs.push_back(make_pair(0, QUARTER + 1, 0, 0));
		pending_pairs.push_back(make_pair(0, HALF + 1, 0, 0));
		pending_pairs.push_back(make_pair(0, -lon_max, 0, lon_max));
		pending_pairs.push_back(make_pair(1000, 5000, 1000, 5000));
		pending_pairs.push_back(make_pair(1000, 5000, 1000, 5001));
		pending_pairs.push_back(make_pair(8388607, 16777215, -8388608, -16777216));
		pending_pairs.push_back(make_pair(-8388608, -16777216, 8388607, 16777215));
		pending_pairs.push_back(make_pair(-8388608, 16777215, -8388608, -16777216));
		pending_pairs.push_back(make_pair(8388607, 0, 8388607, 0));
		pending_pairs.push_back(make_pair(-1, -1, -1, -1));
		for (int i = 0; i < 500; i++) begin
			pending_pairs.push_back(random_pair());
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_dist.push_back(
					polar_distance(point_pair_t'({lat_a, lon_a, lat_b, lon_b})));
			end
			if (start && busy) begin
				// hold the transaction
			end else if (pending_pairs.size() > 0 && gap_left == 0) begin
				point_pair_t p;
				p = pending_pairs.pop_front();
				start <= 1'b1;
				lat_a <= p.lat_a;
				lon_a <= p.lon_a;
				lat_b <= p.lat_b;
				lon_b <= p.lon_b;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
				lat_a <= 24'($urandom);
				lon_a <= 25'($urandom);
				lat_b <= 24'($urandom);
				lon_b <= 25'($urandom);
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end
				if (pending_pairs.size() == 0) begin
					stim_done <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_dist.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected distance_km %0d", distance_km);
				end
			end else begin
				logic [31:0] want;
				want = expected_dist.pop_front();
				if (distance_km !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("distance_km expected %0d actual %0d", want, distance_km);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("flat_earth_polar_distance: mismatch");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (expected_dist.size() > 0) begin
			@(posedge clk);
		end
		repeat (fepd_pkg::LATENCY + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("flat_earth_polar_distance: match");
		end else begin
			$display("flat_earth_polar_distance: mismatch");
		end
		$finish;
	end

endmodule
